// ===== sv/smpp_submit_body_parser_top_defines.svh =====
// Assertion macros shared by the SMPP submit body parser RTL.
`ifndef SMPP_SUBMIT_BODY_PARSER_TOP_DEFINES_SVH
`define SMPP_SUBMIT_BODY_PARSER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SSBP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ssbp assertion failed");
// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SSBP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ssbp assertion failed");
`else
`define SSBP_ASSERT_NOW(lbl, ante, cons)
`define SSBP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== sv/ssbp_pkg.sv =====
// Types, field codes and helpers for the SMPP submit body parser.
`default_nettype none
package ssbp_pkg;

	typedef logic [4:0] field_id_t;
	typedef logic [4:0] cap_t;

	// Field codes in body order
	localparam field_id_t ID_SERVICE_TYPE = 5'd0;
	localparam field_id_t ID_SOURCE_ADDR  = 5'd3;
	localparam field_id_t ID_DEST_ADDR    = 5'd6;
	localparam field_id_t ID_ESM_CLASS    = 5'd7;
	localparam field_id_t ID_SCHED_TIME   = 5'd10;
	localparam field_id_t ID_VALIDITY     = 5'd11;
	localparam field_id_t ID_SM_LENGTH    = 5'd16;
	localparam field_id_t ID_CONCAT_HDR   = 5'd17;
	localparam field_id_t ID_PART_TOTAL   = 5'd18;
	localparam field_id_t ID_PART_NUMBER  = 5'd19;
	localparam field_id_t ID_MESSAGE      = 5'd20;

	localparam cap_t CAP_SERVICE_TYPE = 5'd6;
	localparam cap_t CAP_ADDR         = 5'd21;
	localparam cap_t CAP_TIME         = 5'd17;
	localparam cap_t CAP_NONE         = 5'd0;

	localparam logic [7:0] ESM_CONCAT_MASK   = 8'h40;
	localparam logic [7:0] CONCAT_HDR_LEN    = 8'd6;
	localparam logic [8:0] CONCAT_PREFIX_LEN = 9'd4;

	localparam logic [1:0] OUT_DEPTH = 2'd2;

	typedef struct packed {
		field_id_t  field_id;
		logic [7:0] field_byte;
		logic       field_end;
		logic       truncated;
	} ssbp_result_t;

	typedef struct packed {
		field_id_t field_index;
		logic      parse_done;
	} ssbp_status_t;

	// Length cap of a C-octet string field, CAP_NONE for fields that are not C-octet strings
	function automatic cap_t string_cap(input field_id_t id);
		cap_t cap;
		case (id)
			ID_SERVICE_TYPE: cap = CAP_SERVICE_TYPE;
			ID_SOURCE_ADDR:  cap = CAP_ADDR;
			ID_DEST_ADDR:    cap = CAP_ADDR;
			ID_SCHED_TIME:   cap = CAP_TIME;
			ID_VALIDITY:     cap = CAP_TIME;
			default:         cap = CAP_NONE;
		endcase
		return cap;
	endfunction

endpackage
`default_nettype wire

// ===== sv/smpp_submit_body_parser_top.sv =====
// Top level of the SMPP submit_sm body parser.
// Feed the body of a submit_sm PDU one byte per request on the byte channel,
// with body_last high on its final byte. Each byte of the seventeen header
// fields, of the optional 6-byte concatenation header (when esm_class bit 6
// is set) and of the message comes back as one request on the field channel,
// tagged with its field id, an end-of-field flag and a truncated flag that
// marks a body ending before the message is complete. Bytes after the parse
// completes produce nothing; body_last always rearms the parser for the next
// body. The field tracker decides each byte's tag in one pass of short logic
// and writes it into a two-entry output buffer, so a byte can be taken every
// cycle and byte_ready only drops while both buffer entries are full. The
// tagged result is registered in the output buffer before it is offered.
`default_nettype none
`include "smpp_submit_body_parser_top_defines.svh"
module smpp_submit_body_parser_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        byte_valid,
	output logic             byte_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        body_last,
	output logic             field_valid,
	input  wire logic        field_ready,
	output logic [4:0]       field_id,
	output logic [7:0]       field_byte,
	output logic             field_end,
	output logic             truncated
);

	logic                   take;
	logic                   push;
	logic                   space;
	ssbp_pkg::ssbp_result_t result;
	ssbp_pkg::ssbp_result_t out_data;
	ssbp_pkg::ssbp_status_t status;
	logic                   tracker_at_start;

	// accept a byte whenever the buffer has room, even with a result waiting
	assign byte_ready = space;
	assign take       = byte_valid && byte_ready;

	ssbp_field_tracker u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (data_byte),
		.body_last (body_last),
		.push      (push),
		.result    (result),
		.status    (status)
	);

	ssbp_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (result),
		.space     (space),
		.out_valid (field_valid),
		.out_ready (field_ready),
		.out_data  (out_data)
	);

	assign field_id   = out_data.field_id;
	assign field_byte = out_data.field_byte;
	assign field_end  = out_data.field_end;
	assign truncated  = out_data.truncated;

	// tracker sits at the first field with the parse still open
	assign tracker_at_start = (status.field_index == ssbp_pkg::ID_SERVICE_TYPE) &&
		!status.parse_done;

	// a body end must rearm the tracker at the first field
	`SSBP_ASSERT_NEXT(a_last_rearms, take && body_last, tracker_at_start)
	// tracked field never leaves the known id range
	`SSBP_ASSERT_NOW(a_index_range, 1'b1, status.field_index <= ssbp_pkg::ID_MESSAGE)
	// part total is a single byte field
	`SSBP_ASSERT_NOW(a_total_single, field_valid && (field_id == ssbp_pkg::ID_PART_TOTAL), field_end)

endmodule
`default_nettype wire

// ===== sv/ssbp_field_tracker.sv =====
// Per-byte field tracking state and next-state logic.
`default_nettype none
module ssbp_field_tracker (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  take,
	input  wire logic [7:0]            data_byte,
	input  wire logic                  body_last,
	output logic                       push,
	output ssbp_pkg::ssbp_result_t     result,
	output ssbp_pkg::ssbp_status_t     status
);

	ssbp_pkg::field_id_t field_index_q, field_index_n;
	logic [7:0]          bytes_q, bytes_n;
	logic                concat_q, concat_n;
	logic [7:0]          msg_len_q, msg_len_n;
	logic                done_q, done_n;

	logic [8:0]          cnt;
	ssbp_pkg::cap_t      cap;
	logic                fld_end;
	logic [7:0]          msg_len_cat;

	always_comb begin
		cnt = {1'b0, bytes_q} + 9'd1;
		cap = ssbp_pkg::string_cap(field_index_q);

		if (cap != ssbp_pkg::CAP_NONE) begin
			fld_end = (data_byte == 8'd0) || (cnt >= {4'd0, cap});
		end else if (field_index_q == ssbp_pkg::ID_CONCAT_HDR) begin
			fld_end = cnt >= ssbp_pkg::CONCAT_PREFIX_LEN;
		end else if (field_index_q == ssbp_pkg::ID_MESSAGE) begin
			fld_end = cnt >= {1'b0, msg_len_q};
		end else begin
			fld_end = 1'b1;
		end

		// sm_length less the concatenation header, floored at zero
		msg_len_cat = (data_byte > ssbp_pkg::CONCAT_HDR_LEN) ?
			(data_byte - ssbp_pkg::CONCAT_HDR_LEN) : 8'd0;

		concat_n = concat_q;
		if (field_index_q == ssbp_pkg::ID_ESM_CLASS) begin
			concat_n = (data_byte & ssbp_pkg::ESM_CONCAT_MASK) != 8'd0;
		end
		msg_len_n = msg_len_q;
		if (field_index_q == ssbp_pkg::ID_SM_LENGTH) begin
			msg_len_n = concat_q ? msg_len_cat : data_byte;
		end

		field_index_n = field_index_q;
		bytes_n       = cnt[7:0];
		done_n        = done_q;
		if (fld_end) begin
			bytes_n = 8'd0;
			if (field_index_q == ssbp_pkg::ID_SM_LENGTH) begin
				if (concat_q) begin
					field_index_n = ssbp_pkg::ID_CONCAT_HDR;
				end else if (msg_len_n != 8'd0) begin
					field_index_n = ssbp_pkg::ID_MESSAGE;
				end else begin
					done_n = 1'b1;
				end
			end else if (field_index_q == ssbp_pkg::ID_CONCAT_HDR) begin
				field_index_n = ssbp_pkg::ID_PART_TOTAL;
			end else if (field_index_q == ssbp_pkg::ID_PART_TOTAL) begin
				field_index_n = ssbp_pkg::ID_PART_NUMBER;
			end else if (field_index_q == ssbp_pkg::ID_PART_NUMBER) begin
				if (msg_len_q != 8'd0) begin
					field_index_n = ssbp_pkg::ID_MESSAGE;
				end else begin
					done_n = 1'b1;
				end
			end else if (field_index_q >= ssbp_pkg::ID_MESSAGE) begin
				done_n = 1'b1;
			end else begin
				field_index_n = field_index_q + 5'd1;
			end
		end

		push                = take && !done_q;
		result.field_id     = field_index_q;
		result.field_byte   = data_byte;
		result.field_end    = fld_end;
		result.truncated    = body_last && !done_n;
		status.field_index  = field_index_q;
		status.parse_done   = done_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_index_q <= ssbp_pkg::ID_SERVICE_TYPE;
			bytes_q       <= 8'd0;
			concat_q      <= 1'b0;
			msg_len_q     <= 8'd0;
			done_q        <= 1'b0;
		end else if (take) begin
			if (body_last) begin
				// end of body: back to the first field
				field_index_q <= ssbp_pkg::ID_SERVICE_TYPE;
				bytes_q       <= 8'd0;
				concat_q      <= 1'b0;
				msg_len_q     <= 8'd0;
				done_q        <= 1'b0;
			end else if (!done_q) begin
				field_index_q <= field_index_n;
				bytes_q       <= bytes_n;
				concat_q      <= concat_n;
				msg_len_q     <= msg_len_n;
				done_q        <= done_n;
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/ssbp_out_buf.sv =====
// Two-entry result buffer that decouples the parser from the consumer.
`default_nettype none
module ssbp_out_buf (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire ssbp_pkg::ssbp_result_t push_data,
	output logic                       space,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output ssbp_pkg::ssbp_result_t     out_data
);

	ssbp_pkg::ssbp_result_t entry_q [2];
	logic                   wr_ptr_q, rd_ptr_q;
	logic [1:0]             count_q;
	logic                   pop;

	assign space     = count_q != ssbp_pkg::OUT_DEPTH;
	assign out_valid = count_q != 2'd0;
	assign out_data  = entry_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire
